// ===== sv/nec_pkg.sv =====
// Shared types, constants and register indexes of the NEC edge decoder.
package nec_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned BITCNT_W   = $clog2(FRAME_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ONE       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] HEADER_US_RST    = CFG_W'(13500);
    localparam logic [CFG_W-1:0] ONE_US_RST       = CFG_W'(2250);
    localparam logic [CFG_W-1:0] ZERO_US_RST      = CFG_W'(1125);
    localparam logic [CFG_W-1:0] TOLERANCE_US_RST = CFG_W'(300);

    localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(FRAME_BITS - 1);

    typedef struct packed {
        logic [CFG_W-1:0] header_us;
        logic [CFG_W-1:0] one_us;
        logic [CFG_W-1:0] zero_us;
        logic [CFG_W-1:0] tolerance_us;
    } t_cfg;

    typedef struct packed {
        logic hdr;
        logic one;
        logic zero;
    } t_win_hits;

    typedef enum logic {
        ST_HUNT,
        ST_RECV
    } t_rx_state;

endpackage

// ===== sv/nec_ir_edge_decoder.sv =====
// Top level of the NEC infrared decoder working on edge timestamps.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_edge_time
//   out      source     o_out_valid / i_out_stall  o_frame_done, o_code,
//                                                  o_is_standard, o_is_extended
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word is taken per cycle while o_in_stall is low; it passes the input register
// and then the result register before its result is on the outputs.
// The interval is formed at the input register, the three window compares and the
// frame update sit between the input register and the result register.
// Synchronous active-low reset clears the frame state, the last timestamp and both
// valid bits, and loads the register defaults.
// An output stall holds the result register and backs up into the input register:
// o_in_stall rises in the same cycle when the input register holds a word, else one
// word later.
module nec_ir_edge_decoder
    import nec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TIME_W-1:0]     i_edge_time,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_frame_done,
    output logic [FRAME_BITS-1:0] o_code,
    output logic                  o_is_standard,
    output logic                  o_is_extended,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg              w_cfg;
    t_win_hits         w_hits;
    logic              w_out_ready;
    logic              w_accept;
    logic              r_s1_valid;
    logic [TIME_W-1:0] r_last_edge;
    logic [TIME_W-1:0] r_interval;

    nec_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_in_stall = r_s1_valid && !w_out_ready;
    assign w_accept   = i_in_valid && !o_in_stall;

    // The interval wraps modulo 2^32 like the timestamp itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_last_edge <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid  <= 1'b1;
                r_last_edge <= i_edge_time;
            end else if (w_out_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_interval <= i_edge_time - r_last_edge;
        end
    end

    nec_window u_win_hdr (
        .i_interval  (r_interval),
        .i_nominal   (w_cfg.header_us),
        .i_tolerance (w_cfg.tolerance_us),
        .o_hit       (w_hits.hdr)
    );

    nec_window u_win_one (
        .i_interval  (r_interval),
        .i_nominal   (w_cfg.one_us),
        .i_tolerance (w_cfg.tolerance_us),
        .o_hit       (w_hits.one)
    );

    nec_window u_win_zero (
        .i_interval  (r_interval),
        .i_nominal   (w_cfg.zero_us),
        .i_tolerance (w_cfg.tolerance_us),
        .o_hit       (w_hits.zero)
    );

    nec_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (r_s1_valid),
        .i_hits        (w_hits),
        .i_out_stall   (i_out_stall),
        .o_ready       (w_out_ready),
        .o_out_valid   (o_out_valid),
        .o_frame_done  (o_frame_done),
        .o_code        (o_code),
        .o_is_standard (o_is_standard),
        .o_is_extended (o_is_extended)
    );

endmodule

// ===== sv/nec_cfg_regs.sv =====
// Configuration register file of the NEC edge decoder.
module nec_cfg_regs
    import nec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER:    n_cfg.header_us    = i_cfg_data;
                REG_ONE:       n_cfg.one_us       = i_cfg_data;
                REG_ZERO:      n_cfg.zero_us      = i_cfg_data;
                REG_TOLERANCE: n_cfg.tolerance_us = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_us    <= HEADER_US_RST;
            r_cfg.one_us       <= ONE_US_RST;
            r_cfg.zero_us      <= ZERO_US_RST;
            r_cfg.tolerance_us <= TOLERANCE_US_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/nec_window.sv =====
// Tolerance window compare of one edge interval against one nominal value.
module nec_window
    import nec_pkg::*;
(
    input  logic [TIME_W-1:0] i_interval,
    input  logic [CFG_W-1:0]  i_nominal,
    input  logic [CFG_W-1:0]  i_tolerance,
    output logic              o_hit
);

    logic [TIME_W:0]  w_diff;
    logic [CFG_W-1:0] w_below;

    assign w_diff = {1'b0, i_interval} - {{(TIME_W + 1 - CFG_W){1'b0}}, i_nominal};

    // When the interval is below the nominal value it fits in the low bits.
    assign w_below = i_nominal - i_interval[CFG_W-1:0];

    assign o_hit = w_diff[TIME_W] ? (w_below <= i_tolerance)
                                  : (w_diff[TIME_W-1:0] <=
                                     {{(TIME_W - CFG_W){1'b0}}, i_tolerance});

endmodule

// ===== sv/nec_frame.sv =====
// Frame state machine, bit packer and result register of the NEC edge decoder.
module nec_frame
    import nec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s1_valid,
    input  t_win_hits             i_hits,
    input  logic                  i_out_stall,
    output logic                  o_ready,
    output logic                  o_out_valid,
    output logic                  o_frame_done,
    output logic [FRAME_BITS-1:0] o_code,
    output logic                  o_is_standard,
    output logic                  o_is_extended
);

    t_rx_state             r_state;
    t_rx_state             n_state;
    logic [BITCNT_W-1:0]   r_count;
    logic [BITCNT_W-1:0]   n_count;
    logic [FRAME_BITS-1:0] r_shift;
    logic [FRAME_BITS-1:0] n_shift;
    logic                  r_valid;
    logic                  r_done;
    logic [FRAME_BITS-1:0] r_code;
    logic                  r_std;
    logic                  r_ext;
    logic                  w_advance;
    logic                  w_done;
    logic                  w_std;
    logic                  w_ext;
    logic                  w_lo_ok;
    logic                  w_hi_ok;

    assign o_ready   = !r_valid || !i_out_stall;
    assign w_advance = i_s1_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_shift = r_shift;
        w_done  = 1'b0;
        if (w_advance) begin
            case (r_state)
                ST_HUNT: begin
                    if (i_hits.hdr) begin
                        n_state = ST_RECV;
                        n_count = '0;
                        n_shift = '0;
                    end
                end
                ST_RECV: begin
                    if (i_hits.one || i_hits.zero) begin
                        // A one wins when both bit windows match.
                        n_shift[r_count] = r_shift[r_count] | i_hits.one;
                        n_count          = r_count + 1'b1;
                        if (r_count == LAST_BIT) begin
                            w_done  = 1'b1;
                            n_state = ST_HUNT;
                        end
                    end else if (i_hits.hdr) begin
                        n_count = '0;
                        n_shift = '0;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                default: n_state = ST_HUNT;
            endcase
        end
    end

    // Standard frames carry inverted copies of the address and command bytes.
    assign w_lo_ok = (n_shift[15:8] == ~n_shift[7:0]);
    assign w_hi_ok = (n_shift[31:24] == ~n_shift[23:16]);
    assign w_std   = w_done && w_lo_ok && w_hi_ok;
    assign w_ext   = w_done && w_hi_ok && !w_lo_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_count <= '0;
            r_shift <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_shift <= n_shift;
            if (o_ready) begin
                r_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_done <= w_done;
            r_code <= w_done ? n_shift : '0;
            r_std  <= w_std;
            r_ext  <= w_ext;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_frame_done  = r_done;
    assign o_code        = r_code;
    assign o_is_standard = r_std;
    assign o_is_extended = r_ext;

`ifndef SYNTHESIS
    a_done_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_done) |=> (r_state == ST_HUNT))
        else $error("state machine did not return to hunting after a frame");

    a_hunt_holds_without_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_state == ST_HUNT) && !i_hits.hdr) |=> (r_state == ST_HUNT))
        else $error("left hunting without a header interval");

    a_no_frame_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_code == '0))
        else $error("nonzero code without a completed frame");

    a_flags_need_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_is_standard || o_is_extended)) |-> o_frame_done)
        else $error("frame type flag without a completed frame");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_standard && o_is_extended))
        else $error("frame flagged both standard and extended");
`endif

endmodule
